[design/pcbt_pkg.sv]
// ----------------------------------------------------------------------------
// PC breakpoint table package
// Shared command and status codes, payload structs and cell control struct.
// ----------------------------------------------------------------------------
package pcbt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ADDR_W          = 12;
  localparam int COUNT_OUT_W     = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    status_t                status;
    logic                   hit;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic add_we;
    logic rem_shift;
  } ctl_t;

endpackage

[design/pcbt_cell.sv]
// ----------------------------------------------------------------------------
// PC breakpoint table cell
// Holds one breakpoint address, compares it with the lookup key and takes
// its right neighbor's address when an entry at or before it is removed.
// ----------------------------------------------------------------------------
module pcbt_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 5
) (
  input  logic                       clk,
  input  logic [COUNT_W-1:0]         count,
  input  pcbt_pkg::ctl_t             ctl,
  input  logic [pcbt_pkg::ADDR_W-1:0] key,
  input  logic                       match_in,
  input  logic [pcbt_pkg::ADDR_W-1:0] next_addr,
  output logic [pcbt_pkg::ADDR_W-1:0] addr_o,
  output logic                       match_o
);

  logic [pcbt_pkg::ADDR_W-1:0] addr_r;
  logic [pcbt_pkg::ADDR_W-1:0] addr_nxt;
  logic                        valid;
  logic                        here;

  assign valid   = (count > COUNT_W'(INDEX));
  assign here    = valid && (addr_r == key);
  assign match_o = match_in | here;
  assign addr_o  = addr_r;

  always_comb begin
    addr_nxt = addr_r;
    if (ctl.add_we && (count == COUNT_W'(INDEX))) begin
      addr_nxt = key;
    end else if (ctl.rem_shift && match_o) begin
      addr_nxt = next_addr;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

endmodule

[design/pc_breakpoint_table_core.sv]
// ----------------------------------------------------------------------------
// PC breakpoint table core
// Add, remove, check and clear of program-counter breakpoints held in a row
// of cells in insertion order.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload  Handshake
// in_      input      in_t     in_valid / in_ready
// out_     output     out_t    out_valid / out_ready
//
// Each command's result is registered and appears the cycle after its input
// transfer, and a new item is taken every cycle unless a result is stalled.
// The rate is set by the combinational cell compare chain and output register.
// Reset clears the entry count and the output valid; entries need no clearing.
// While a result is stalled at the output, in_ready stays low.
// ----------------------------------------------------------------------------
module pc_breakpoint_table_core #(
  parameter int MAX_ENTRIES = pcbt_pkg::MAX_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcbt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pcbt_pkg::out_t out_data
);

  localparam int COUNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int AW            = pcbt_pkg::ADDR_W;
  localparam int COUNT_OUT_PAD = pcbt_pkg::COUNT_OUT_W;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  pcbt_pkg::out_t     out_data_r;
  pcbt_pkg::out_t     out_data_nxt;

  logic                      accept;
  logic                      full;
  logic                      hit;
  pcbt_pkg::ctl_t            ctl;
  logic [MAX_ENTRIES:0]      match_chain;
  logic [AW-1:0]             addrs [MAX_ENTRIES];
  logic [COUNT_W+COUNT_OUT_PAD-1:0] count_ext;

  assign in_ready       = !out_valid_r || out_ready;
  assign accept         = in_valid && in_ready;
  assign full           = (count_r == COUNT_W'(MAX_ENTRIES));
  assign match_chain[0] = 1'b0;
  assign hit            = match_chain[MAX_ENTRIES];

  assign ctl.add_we    = accept && (in_data.cmd == pcbt_pkg::CMD_ADD) && !full && !hit;
  assign ctl.rem_shift = accept && (in_data.cmd == pcbt_pkg::CMD_REMOVE);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [AW-1:0] next_addr;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign next_addr = addrs[i];
    end else begin : g_mid
      assign next_addr = addrs[i+1];
    end
    pcbt_cell #(
      .INDEX   (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk       (clk),
      .count     (count_r),
      .ctl       (ctl),
      .key       (in_data.address),
      .match_in  (match_chain[i]),
      .next_addr (next_addr),
      .addr_o    (addrs[i]),
      .match_o   (match_chain[i+1])
    );
  end

  always_comb begin
    count_nxt            = count_r;
    out_data_nxt.status  = pcbt_pkg::ST_DONE;
    out_data_nxt.hit     = 1'b0;
    unique case (in_data.cmd)
      pcbt_pkg::CMD_ADD: begin
        if (full) begin
          out_data_nxt.status = pcbt_pkg::ST_FULL;
        end else if (hit) begin
          out_data_nxt.status = pcbt_pkg::ST_PRESENT;
        end else begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      pcbt_pkg::CMD_REMOVE: begin
        if (hit) begin
          count_nxt = count_r - COUNT_W'(1);
        end else begin
          out_data_nxt.status = pcbt_pkg::ST_NOT_FOUND;
        end
      end
      pcbt_pkg::CMD_CHECK: begin
        if (hit) begin
          out_data_nxt.hit = 1'b1;
        end else begin
          out_data_nxt.status = pcbt_pkg::ST_NOT_FOUND;
        end
      end
      pcbt_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    count_ext                = (COUNT_W + COUNT_OUT_PAD)'(count_nxt);
    out_data_nxt.entry_count = count_ext[pcbt_pkg::COUNT_OUT_W-1:0];
    out_valid_nxt            = accept || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/pcbt_checker.sv]
// ----------------------------------------------------------------------------
// PC breakpoint table checker
// Port-level assertions on transfers and results of the breakpoint table.
// ----------------------------------------------------------------------------
module pcbt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input pcbt_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input pcbt_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == pcbt_pkg::CMD_CLEAR)
    |=> (out_data.entry_count == '0) && (out_data.status == pcbt_pkg::ST_DONE))
    else $error("clear left entries");

  a_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == pcbt_pkg::CMD_CHECK)
    |=> (out_data.hit && (out_data.status == pcbt_pkg::ST_DONE)) ||
        (!out_data.hit && (out_data.status == pcbt_pkg::ST_NOT_FOUND)))
    else $error("check result inconsistent");

endmodule

bind pc_breakpoint_table_core pcbt_checker u_pcbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/pc_breakpoint_table_checker.sv]
// ----------------------------------------------------------------------------
// PC breakpoint table checker
// Watches both channels of the breakpoint table. It keeps its own copy of the
// table and predicts the result of every input transfer. It then compares each
// result transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pc_breakpoint_table_checker
  import pcbt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending_count
);

  logic [ADDR_W-1:0] bp_table [MAX_ENTRIES];
  int                bp_count;
  out_t              expected_outcomes [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    bp_count      = 0;
  end

  function automatic int locate_breakpoint(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < bp_count; i++) begin
      if (bp_table[i] == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic out_t apply_command(in_t item);
    out_t res;
    int   pos;
    res.status = ST_DONE;
    res.hit    = 1'b0;
    case (item.cmd)
      CMD_ADD: begin
        if (bp_count >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else if (locate_breakpoint(item.address) >= 0) begin
          res.status = ST_PRESENT;
        end else begin
          bp_table[bp_count] = item.address;
          bp_count++;
        end
      end
      CMD_REMOVE: begin
        pos = locate_breakpoint(item.address);
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < bp_count; i++) begin
            bp_table[i] = bp_table[i + 1];
          end
          bp_count--;
        end
      end
      CMD_CHECK: begin
        if (locate_breakpoint(item.address) >= 0) begin
          res.hit = 1'b1;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        bp_count = 0;
      end
    endcase
    res.entry_count = COUNT_OUT_W'(bp_count);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      bp_count = 0;
      expected_outcomes.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_outcomes.push_back(apply_command(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected (status %0d)",
                                    out_data.status));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_data.status, want.status));
          end
          if (out_data.hit !== want.hit) begin
            report_mismatch($sformatf("hit got %0d expected %0d", out_data.hit, want.hit));
          end
          if (out_data.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_data.entry_count, want.entry_count));
          end
        end
      end
    end
    pending_count = expected_outcomes.size();
  end

endmodule

[tb/sv/pc_breakpoint_table_core_tb.sv]
// ----------------------------------------------------------------------------
// PC breakpoint table testbench
// Drives add, remove, check and clear commands into the breakpoint table: a
// directed opening, then random traffic over a small address pool so that the
// table fills, hits and shifts often. Both sides idle in random bursts, and
// the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module pc_breakpoint_table_core_tb;
  import pcbt_pkg::*;

  localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int POOL_SIZE    = 24;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   fail_count;
  int   pending_count;
  bit   tx_idle_on    = 1'b1;
  bit   rx_idle_on    = 1'b1;
  bit   hold_off_req  = 1'b0;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  always #2 clk = ~clk;

  pc_breakpoint_table_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  pc_breakpoint_table_checker #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  task automatic send_command(cmd_t cmd, logic [ADDR_W-1:0] addr);
    in_t item;
    item.cmd     = cmd;
    item.address = addr;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic cmd_t pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return CMD_ADD;
    end else if (roll < 65) begin
      return CMD_REMOVE;
    end else if (roll < 95) begin
      return CMD_CHECK;
    end
    return CMD_CLEAR;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 9) < 7) begin
      return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return ADDR_W'($urandom);
  endfunction

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int burst;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 19);
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        burst = $urandom_range(1, 30);
        repeat (burst) @(posedge clk);
      end
    end
  end

  initial begin
    int gap;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      addr_pool[k] = ADDR_W'($urandom);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(CMD_CHECK, 12'h000);
    send_command(CMD_REMOVE, 12'h000);
    send_command(CMD_ADD, 12'h000);
    send_command(CMD_ADD, 12'hFFF);
    send_command(CMD_ADD, 12'hFFF);
    send_command(CMD_CHECK, 12'hFFF);
    send_command(CMD_REMOVE, 12'h000);
    send_command(CMD_CLEAR, 12'hFFF);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      send_command(CMD_ADD, ADDR_W'(k * 257));
    end
    send_command(CMD_ADD, 12'h000);
    send_command(CMD_REMOVE, 12'h505);
    send_command(CMD_CHECK, 12'hF0F);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        hold_off_req = 1'b1;
      end
      if (i == 500) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_command(pick_command(), pick_address());
      if (i == 300) begin
        in_valid <= 1'b0;
        drain_results();
      end else if (tx_idle_on && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
